// ----- rtl/core/ccd_pixel_stripe_demux_defines.svh -----
// ----------------------------------------------------------------------------
// ccd_pixel_stripe_demux_defines
// Assertion macros shared by the stripe demux checker.
// ----------------------------------------------------------------------------
`ifndef CCD_PIXEL_STRIPE_DEMUX_DEFINES_SVH
`define CCD_PIXEL_STRIPE_DEMUX_DEFINES_SVH

// Concurrent property on the rising clock, off while reset is asserted.
`define CCD_PSD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge out of reset.
`define CCD_PSD_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`endif

// ----- rtl/core/ccd_psd_pkg.sv -----
// ----------------------------------------------------------------------------
// ccd_psd_pkg
// Widths, reset values, register codes and shared types of the stripe demux.
// ----------------------------------------------------------------------------
package ccd_psd_pkg;

  // Geometry
  localparam int NUM_STRIPES  = 3;
  localparam int NUM_CHANNELS = 16;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 2048;

  // Field widths
  localparam int STRIPE_W = 2;
  localparam int EN_W     = 3;
  localparam int CHAN_W   = 4;
  localparam int WIDX_W   = 25;
  localparam int CNT_W    = 26;  // holds the full stripe size itself
  localparam int COL_W    = 10;
  localparam int ROW_W    = 11;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int WORD_W   = 16;
  localparam int PIX_W    = 18;

  // Port widths
  localparam int IN_TDATA_W  = WORD_W;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_PAY_W   = WIDX_W + CHAN_W + COL_W + ROW_W + PIX_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_PAY_W;
  localparam int OUT_TUSER_W = STRIPE_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = HEIGHT_W;

  // Constants
  localparam logic [PIX_W-1:0]    PIX_XOR      = 18'h1FFFF;
  localparam logic [EN_W-1:0]     EN_RESET     = 3'd7;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd512;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd2000;
  localparam logic [CNT_W-1:0]    FSIZE_RESET  = CNT_W'(512 * 2000 * NUM_CHANNELS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIPE_ENABLE = 2'd0,
    CFG_LINE_WIDTH    = 2'd1,
    CFG_FRAME_HEIGHT  = 2'd2
  } cfg_idx_t;

  // Per-stripe write position
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } stripe_ctr_t;

  // Location of one word inside its stripe
  typedef struct packed {
    logic [WIDX_W-1:0] word_index;
    logic [CHAN_W-1:0] channel;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic              overrun;
  } locate_res_t;

endpackage

// ----- rtl/core/ccd_psd_locate.sv -----
// ----------------------------------------------------------------------------
// ccd_psd_locate
// Places one word in its stripe buffer and advances that stripe's counters.
// ----------------------------------------------------------------------------
module ccd_psd_locate
  import ccd_psd_pkg::*;
(
  input  stripe_ctr_t          ctr,
  input  logic [WIDTH_W-1:0]   width,
  input  logic [HEIGHT_W-1:0]  height,
  input  logic [CNT_W-1:0]     fsize,
  output locate_res_t          res,
  output stripe_ctr_t          ctr_nxt
);

  logic             full;
  logic [CNT_W-1:0] last_idx;
  logic [WIDTH_W-1:0] col_inc;
  logic [WIDTH_W-1:0] width_m1;
  logic [HEIGHT_W-1:0] height_m1;

  assign full      = (ctr.count >= fsize);
  assign last_idx  = fsize - CNT_W'(1);
  assign col_inc   = {1'b0, ctr.col} + WIDTH_W'(1);
  assign width_m1  = width - WIDTH_W'(1);
  assign height_m1 = height - HEIGHT_W'(1);

  always_comb begin
    res     = '0;
    ctr_nxt = ctr;
    if (full) begin
      // hold at the last position of the stripe
      res.word_index = last_idx[WIDX_W-1:0];
      res.channel    = last_idx[CHAN_W-1:0];
      res.column     = width_m1[COL_W-1:0];
      res.row        = height_m1[ROW_W-1:0];
      res.overrun    = 1'b1;
    end else begin
      res.word_index = ctr.count[WIDX_W-1:0];
      res.channel    = ctr.count[CHAN_W-1:0];
      res.column     = ctr.col;
      res.row        = ctr.row;
      res.overrun    = 1'b0;
      ctr_nxt.count  = ctr.count + CNT_W'(1);
      // last channel of a column: step the column, wrap into the next row
      if (ctr.count[CHAN_W-1:0] == CHAN_W'(NUM_CHANNELS - 1)) begin
        if (col_inc >= width) begin
          ctr_nxt.col = '0;
          ctr_nxt.row = ctr.row + ROW_W'(1);
        end else begin
          ctr_nxt.col = col_inc[COL_W-1:0];
        end
      end
    end
  end

endmodule

// ----- rtl/core/ccd_pixel_stripe_demux.sv -----
// ----------------------------------------------------------------------------
// ccd_pixel_stripe_demux
// Converts camera pixel words and routes them over the enabled stripes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one raw 16-bit pixel word per request, network byte order, in
//            tdata; tuser[0] flags the first word of a frame and clears all
//            stripe counters before the word is placed.
//   out_*  : one result per word: location fields and converted pixel in
//            tdata, stripe index and overrun flag in tuser. With no stripe
//            enabled the word is dropped and no result is sent.
//   cfg_*  : register writes (stripe enable, line width, frame height),
//            always ready; issue them only while no word is in flight.
// Throughput is one word per cycle while the receiver keeps up: a word sits in
// the input register, where the stripe selection and the counter update of the
// single locate unit run, and is then loaded into the output register.
// out_tvalid, out_tdata and out_tuser come straight from the output register.
// When the receiver stalls, the result holds in the output register and one
// more word waits in the input register; in_tready then drops.
// Reset clears all counters, sets the enable mask to all stripes, the line
// width to 512 and the frame height to 2000.
// ----------------------------------------------------------------------------
module ccd_pixel_stripe_demux
  import ccd_psd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] pixel_word
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] frame_start
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [24:0] word_index, [28:25] channel, [38:29] column, [49:39] row,
  // [67:50] pixel_value, [71:68] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [1:0] stripe_index, [2] overrun
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // next enabled stripe at or after 'from', cyclic; zero for an empty mask
  function automatic logic [STRIPE_W-1:0] find_enabled(
    input logic [STRIPE_W-1:0] from,
    input logic [EN_W-1:0]     mask
  );
    logic [STRIPE_W-1:0] s;
    logic [STRIPE_W-1:0] pick;
    logic                found;
    s     = (from >= STRIPE_W'(NUM_STRIPES)) ? from - STRIPE_W'(NUM_STRIPES) : from;
    pick  = '0;
    found = 1'b0;
    for (int k = 0; k < NUM_STRIPES; k++) begin
      if (!found && mask[s]) begin
        pick  = s;
        found = 1'b1;
      end
      s = (s == STRIPE_W'(NUM_STRIPES - 1)) ? '0 : s + STRIPE_W'(1);
    end
    return pick;
  endfunction

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    if (v == '0) return WIDTH_W'(1);
    else if (v > WIDTH_W'(MAX_WIDTH)) return WIDTH_W'(MAX_WIDTH);
    else return v;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
    if (v == '0) return HEIGHT_W'(1);
    else if (v > HEIGHT_W'(MAX_HEIGHT)) return HEIGHT_W'(MAX_HEIGHT);
    else return v;
  endfunction

  // configuration
  logic [EN_W-1:0]     en_r, en_nxt;
  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [CNT_W-1:0]    fsize_r, fsize_nxt;
  logic [WIDTH_W+HEIGHT_W-1:0] area;

  // input register
  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              s1_fs_r;

  // routing state
  logic [STRIPE_W-1:0] cur_r, cur_nxt;
  logic [CHAN_W-1:0]   gc_r, gc_nxt;
  logic                seen_r, seen_nxt;
  stripe_ctr_t         ctr_r   [NUM_STRIPES];
  stripe_ctr_t         ctr_nxt [NUM_STRIPES];

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  logic                has_result;
  logic                advance;
  logic [STRIPE_W-1:0] first_sel;
  logic [STRIPE_W-1:0] eff_cur;
  logic [CHAN_W-1:0]   eff_gc;
  logic                eff_seen;
  logic [STRIPE_W-1:0] sel;
  stripe_ctr_t         ctr_sel;
  stripe_ctr_t         ctr_upd;
  locate_res_t         loc;
  logic [WORD_W-1:0]   swapped;
  logic [PIX_W-1:0]    pix;

  // Register writes; stripe size follows the clamped dimensions
  assign cfg_ready = 1'b1;

  always_comb begin
    en_nxt     = en_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRIPE_ENABLE: en_nxt     = cfg_data[EN_W-1:0];
        CFG_LINE_WIDTH:    width_nxt  = clamp_width(cfg_data[WIDTH_W-1:0]);
        CFG_FRAME_HEIGHT:  height_nxt = clamp_height(cfg_data);
        default: ;
      endcase
    end
  end

  assign area      = width_nxt * height_nxt;
  assign fsize_nxt = {area[CNT_W-CHAN_W-1:0], {CHAN_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= EN_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      fsize_r  <= FSIZE_RESET;
    end else begin
      en_r     <= en_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      fsize_r  <= fsize_nxt;
    end
  end

  // Handshake: drop needs no output slot, a result needs a free or draining one
  assign has_result = (en_r != '0);
  assign advance    = s1_valid_r && (!has_result || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r <= in_tdata[WORD_W-1:0];
      s1_fs_r   <= in_tuser[0];
    end
  end

  // Stripe selection: frame start restarts from the first enabled stripe
  assign first_sel = find_enabled('0, en_r);
  assign eff_cur   = s1_fs_r ? first_sel : cur_r;
  assign eff_gc    = s1_fs_r ? '0 : gc_r;
  assign eff_seen  = s1_fs_r ? 1'b0 : seen_r;
  assign sel       = (eff_seen && eff_gc == '0) ? find_enabled(eff_cur + STRIPE_W'(1), en_r)
                                                : find_enabled(eff_cur, en_r);
  assign ctr_sel   = s1_fs_r ? '0 : ctr_r[sel];

  ccd_psd_locate u_locate (
    .ctr     (ctr_sel),
    .width   (width_r),
    .height  (height_r),
    .fsize   (fsize_r),
    .res     (loc),
    .ctr_nxt (ctr_upd)
  );

  // Pixel conversion: byte swap, scale by four, flip the low 17 bits
  assign swapped = {s1_word_r[7:0], s1_word_r[15:8]};
  assign pix     = {swapped, 2'b00} ^ PIX_XOR;

  // Next routing state
  always_comb begin
    cur_nxt  = cur_r;
    gc_nxt   = gc_r;
    seen_nxt = seen_r;
    for (int i = 0; i < NUM_STRIPES; i++) begin
      ctr_nxt[i] = s1_fs_r ? '0 : ctr_r[i];
    end
    if (s1_fs_r) begin
      cur_nxt  = first_sel;
      gc_nxt   = '0;
      seen_nxt = 1'b0;
    end
    if (has_result) begin
      cur_nxt      = sel;
      gc_nxt       = eff_gc + CHAN_W'(1);
      seen_nxt     = 1'b1;
      ctr_nxt[sel] = ctr_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      gc_r   <= '0;
      seen_r <= 1'b0;
      for (int i = 0; i < NUM_STRIPES; i++) begin
        ctr_r[i] <= '0;
      end
    end else if (advance) begin
      cur_r  <= cur_nxt;
      gc_r   <= gc_nxt;
      seen_r <= seen_nxt;
      for (int i = 0; i < NUM_STRIPES; i++) begin
        ctr_r[i] <= ctr_nxt[i];
      end
    end
  end

  // Output register: load on a result, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, pix, loc.row, loc.column, loc.channel,
                     loc.word_index};
      out_user_r <= {loc.overrun, sel};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- rtl/core/ccd_psd_checker.sv -----
// ----------------------------------------------------------------------------
// ccd_psd_checker
// Port-level checks on the stripe demux result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ccd_pixel_stripe_demux_defines.svh"

module ccd_psd_checker
  import ccd_psd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // Hold a stalled result unchanged
  `CCD_PSD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed or dropped")

  // Stripe index stays within the stripes that exist
  `CCD_PSD_NEVER(a_stripe_range, clk, rst_n, out_tvalid && out_tuser[1:0] == 2'd3, "stripe index out of range")

  // Channel follows the low bits of the word index
  `CCD_PSD_NEVER(a_chan_idx, clk, rst_n, out_tvalid && out_tdata[28:25] != out_tdata[3:0], "channel does not match word index")

  // Overrun reports the last channel of the stripe
  `CCD_PSD_NEVER(a_ovr_chan, clk, rst_n, out_tvalid && out_tuser[2] && out_tdata[28:25] != 4'hF, "overrun not at last channel")

endmodule

bind ccd_pixel_stripe_demux ccd_psd_checker u_ccd_psd_checker (.*);

// ----- tb/ccd_pixel_stripe_demux_test.sv -----
// ----------------------------------------------------------------------------
// ccd_pixel_stripe_demux_test
// Self-checking bench for the pixel stripe demux: a short table of directed
// words and register settings, then randomized phases with varying stripe
// masks, plane sizes and flow-control pressure on both streams. Every result
// is checked field by field against its table entry or a cycle-free model of
// the stripe routing, the per-stripe write positions and the pixel conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ccd_pixel_stripe_demux_test;
  import ccd_psd_pkg::*;

  localparam int CLK_HALF_NS    = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RAND_PHASES    = 12;
  localparam int EMPTY_PHASE    = 5;
  localparam int TIMEOUT_CYCLES = 400000;

  // Expected placement of one word
  typedef struct packed {
    logic [STRIPE_W-1:0] stripe;
    logic [WIDX_W-1:0]   word_index;
    logic [CHAN_W-1:0]   channel;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
    logic [PIX_W-1:0]    pixel;
    logic                overrun;
  } pixel_loc_t;

  // Result tdata layout, top bits first
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [PIX_W-1:0]     pixel;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     column;
    logic [CHAN_W-1:0]    channel;
    logic [WIDX_W-1:0]    word_index;
  } out_beat_t;

  typedef enum logic {PLAN_WORD, PLAN_CFG} plan_kind_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    plan_kind_t            kind;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [WORD_W-1:0]     word;
    logic                  frame_start;
    int                    reps;
    bit                    typed;
    pixel_loc_t            want;
  } plan_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index  = CFG_STRIPE_ENABLE;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Model of the register file and the stripe write positions
  logic [EN_W-1:0]     pred_enable;
  logic [WIDTH_W-1:0]  pred_width;
  logic [HEIGHT_W-1:0] pred_height;
  int                  sel_stripe;
  logic [CHAN_W-1:0]   group_pos;
  bit                  word_seen;
  logic [CNT_W-1:0]    fill_count [NUM_STRIPES];
  int                  fill_col [NUM_STRIPES];
  int                  fill_row [NUM_STRIPES];

  pixel_loc_t loc_q[$];

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int overruns_seen = 0;
  int words_sent   = 0;
  int dropped_words = 0;
  int frame_starts = 0;
  int cfg_writes   = 0;

  pixel_loc_t want_loc;
  out_beat_t  got_beat;

  ccd_pixel_stripe_demux dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stripe routing model
  // ---------------------------------------------------------------------------

  // First enabled stripe at or after from, wrapping around
  function automatic int next_enabled(input int from, input logic [EN_W-1:0] mask);
    int s;
    int k;
    s = from % NUM_STRIPES;
    for (k = 0; k < NUM_STRIPES; k++) begin
      if (mask[s]) return s;
      s = (s + 1) % NUM_STRIPES;
    end
    return 0;
  endfunction

  function automatic void clear_fill();
    int i;
    group_pos = '0;
    word_seen = 1'b0;
    for (i = 0; i < NUM_STRIPES; i++) begin
      fill_count[i] = '0;
      fill_col[i]   = 0;
      fill_row[i]   = 0;
    end
  endfunction

  // Advance the model by one word; return 1 when the word yields a result
  function automatic bit place_word(input logic [WORD_W-1:0] word, input logic frame_start,
                                    output pixel_loc_t loc);
    int wd;
    int ht;
    int s;
    int idx;
    int fsize;
    logic [WORD_W-1:0] swapped;
    loc = '0;
    if (frame_start) begin
      clear_fill();
      sel_stripe = (pred_enable != '0) ? next_enabled(0, pred_enable) : 0;
    end
    // drop the word with every stripe off
    if (pred_enable == '0) return 1'b0;

    // clamp the plane size
    wd = int'(pred_width);
    ht = int'(pred_height);
    if (wd < 1) wd = 1;
    if (wd > MAX_WIDTH) wd = MAX_WIDTH;
    if (ht < 1) ht = 1;
    if (ht > MAX_HEIGHT) ht = MAX_HEIGHT;

    // rotate after a full group, skip disabled stripes
    sel_stripe = next_enabled(sel_stripe + ((word_seen && group_pos == '0) ? 1 : 0),
                              pred_enable);
    s = sel_stripe;

    swapped    = {word[7:0], word[15:8]};
    loc.stripe = STRIPE_W'(s);
    loc.pixel  = {swapped, 2'b00} ^ PIX_XOR;

    fsize = wd * ht * NUM_CHANNELS;
    if (int'(fill_count[s]) >= fsize) begin
      // full stripe: hold at the last position
      loc.overrun = 1'b1;
      idx         = fsize - 1;
      loc.column  = COL_W'(wd - 1);
      loc.row     = ROW_W'(ht - 1);
    end else begin
      idx           = int'(fill_count[s]);
      loc.column    = COL_W'(fill_col[s]);
      loc.row       = ROW_W'(fill_row[s]);
      fill_count[s] = fill_count[s] + 1'b1;
      if (idx % NUM_CHANNELS == NUM_CHANNELS - 1) begin
        fill_col[s] = fill_col[s] + 1;
        if (fill_col[s] >= wd) begin
          fill_col[s] = 0;
          fill_row[s] = (fill_row[s] + 1) & 16'hFFFF;
        end
      end
    end
    loc.word_index = WIDX_W'(idx);
    loc.channel    = CHAN_W'(idx % NUM_CHANNELS);
    group_pos      = group_pos + 1'b1;
    word_seen      = 1'b1;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one word request and record its expected placement on accept
  task automatic send_word(input logic [WORD_W-1:0] word, input logic fs,
                           input bit typed, input pixel_loc_t want);
    pixel_loc_t loc;
    bit         has_res;
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    has_res = place_word(word, fs, loc);
    if (has_res) loc_q.push_back(typed ? want : loc);
    else dropped_words++;
    if (fs) frame_starts++;
    words_sent++;
  endtask

  // Hold the input until every expected result is out, then let the pipe drain
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (loc_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STRIPE_ENABLE: pred_enable = data[EN_W-1:0];
      CFG_LINE_WIDTH:    pred_width  = data[WIDTH_W-1:0];
      CFG_FRAME_HEIGHT:  pred_height = data[HEIGHT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // Plane dimension write data: mostly tiny, sometimes zero, max or past max
  function automatic logic [CFG_DATA_W-1:0] pick_dim(input int max_dim, input int field_w);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = max_dim;
      2:       v = $urandom_range(max_dim + 1, (1 << field_w) - 1);
      default: v = $urandom_range(1, 3);
    endcase
    if (field_w < CFG_DATA_W) v = v | ($urandom_range(0, 1) << field_w);
    return CFG_DATA_W'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] enable_data(input logic [EN_W-1:0] en);
    return CFG_DATA_W'(($urandom_range(0, 511) << EN_W) | en);
  endfunction

  function automatic plan_row_t plan_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r          = '0;
    r.kind     = PLAN_CFG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic plan_row_t plan_word(input logic [WORD_W-1:0] word, input logic fs,
                                          input int reps);
    plan_row_t r;
    r             = '0;
    r.kind        = PLAN_WORD;
    r.word        = word;
    r.frame_start = fs;
    r.reps        = reps;
    return r;
  endfunction

  function automatic plan_row_t plan_typed(input logic [WORD_W-1:0] word, input logic fs,
                                           input pixel_loc_t want);
    plan_row_t r;
    r       = plan_word(word, fs, 1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = out_tdata;
      if (loc_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %h tuser %h",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want_loc = loc_q.pop_front();
        check_field("stripe_index", 32'(want_loc.stripe), 32'(out_tuser[STRIPE_W-1:0]));
        check_field("word_index", 32'(want_loc.word_index), 32'(got_beat.word_index));
        check_field("channel", 32'(want_loc.channel), 32'(got_beat.channel));
        check_field("column", 32'(want_loc.column), 32'(got_beat.column));
        check_field("row", 32'(want_loc.row), 32'(got_beat.row));
        check_field("pixel_value", 32'(want_loc.pixel), 32'(got_beat.pixel));
        check_field("overrun", 32'(want_loc.overrun), 32'(out_tuser[STRIPE_W]));
        check_field("tdata pad", 32'd0, 32'(got_beat.pad));
        results_seen++;
        if (want_loc.overrun) overruns_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t  plan[$];
    idle_mode_t mode;
    int         phase;
    int         i;
    int         k;
    int         n_items;
    int         hold_at;
    logic       fs;
    logic [EN_W-1:0] en;

    // model state after reset
    pred_enable = EN_RESET;
    pred_width  = WIDTH_RESET;
    pred_height = HEIGHT_RESET;
    clear_fill();
    sel_stripe = next_enabled(0, pred_enable);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    // first words after reset: zero and all-ones pixels
    plan.push_back(plan_typed(16'h0000, 1'b1, '{stripe: 2'd0, word_index: 25'd0,
      channel: 4'd0, column: 10'd0, row: 11'd0, pixel: 18'h1FFFF, overrun: 1'b0}));
    plan.push_back(plan_typed(16'hFFFF, 1'b0, '{stripe: 2'd0, word_index: 25'd1,
      channel: 4'd1, column: 10'd0, row: 11'd0, pixel: 18'h20003, overrun: 1'b0}));
    // dimensions past their maximum clamp to the largest plane
    plan.push_back(plan_cfg(CFG_LINE_WIDTH, 12'hFFF));
    plan.push_back(plan_cfg(CFG_FRAME_HEIGHT, 12'hFFF));
    plan.push_back(plan_word(16'h8000, 1'b0, 1));
    // left stripe only, zero dimensions clamp to one: sixteen words fill it
    plan.push_back(plan_cfg(CFG_STRIPE_ENABLE, 12'hAB9));
    plan.push_back(plan_cfg(CFG_LINE_WIDTH, 12'h800));
    plan.push_back(plan_cfg(CFG_FRAME_HEIGHT, 12'h000));
    plan.push_back(plan_word(16'h0100, 1'b1, 16));
    // next group lands on the full stripe
    plan.push_back(plan_typed(16'h00FF, 1'b0, '{stripe: 2'd0, word_index: 25'd15,
      channel: 4'd15, column: 10'd0, row: 11'd0, pixel: 18'h203FF, overrun: 1'b1}));
    // empty mask drops the word
    plan.push_back(plan_cfg(CFG_STRIPE_ENABLE, 12'h0F8));
    plan.push_back(plan_word(16'hABCD, 1'b0, 1));
    // selected stripe now disabled: skip to the middle one
    plan.push_back(plan_cfg(CFG_STRIPE_ENABLE, 12'h006));
    plan.push_back(plan_typed(16'h8001, 1'b0, '{stripe: 2'd1, word_index: 25'd0,
      channel: 4'd0, column: 10'd0, row: 11'd0, pixel: 18'h1F9FF, overrun: 1'b0}));
    // right stripe only, mid-frame size change
    plan.push_back(plan_cfg(CFG_STRIPE_ENABLE, 12'h004));
    plan.push_back(plan_cfg(CFG_LINE_WIDTH, 12'h002));
    plan.push_back(plan_cfg(CFG_FRAME_HEIGHT, 12'h001));
    plan.push_back(plan_word(16'h7F7F, 1'b0, 3));
    // frame start with an empty mask
    plan.push_back(plan_cfg(CFG_STRIPE_ENABLE, 12'h000));
    plan.push_back(plan_word(16'h5555, 1'b1, 1));

    foreach (plan[r]) begin
      if (plan[r].kind == PLAN_CFG) begin
        settle_idle();
        write_reg(plan[r].reg_idx, plan[r].reg_data);
      end else begin
        for (k = 0; k < plan[r].reps; k++)
          send_word(plan[r].word + WORD_W'(k), plan[r].frame_start && (k == 0),
                    plan[r].typed, plan[r].want);
      end
    end

    // Random phases
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      settle_idle();
      mode = idle_mode_t'(phase % 4);
      case (mode)
        IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin send_gap_pct = 52; stall_pct = 0;  end
        IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 52; end
        default:       begin send_gap_pct = 34; stall_pct = 34; end
      endcase

      // pick this phase's register settings
      if (phase == EMPTY_PHASE) en = '0;
      else if (phase == 1) en = 3'd7;
      else if (phase == 2) en = 3'd1;
      else en = EN_W'($urandom_range(1, 7));
      write_reg(CFG_STRIPE_ENABLE, enable_data(en));
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_reg(CFG_LINE_WIDTH, pick_dim(MAX_WIDTH, WIDTH_W));
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_reg(CFG_FRAME_HEIGHT, pick_dim(MAX_HEIGHT, HEIGHT_W));

      n_items = (phase == EMPTY_PHASE) ? 20 : $urandom_range(90, 130);
      hold_at = (phase % 3 == 0) ? $urandom_range(10, 60) : -1;
      for (i = 0; i < n_items; i++) begin
        // pause the sender until every result is out
        if (i == hold_at) settle_idle();
        if (i == 0) fs = ($urandom_range(0, 3) != 0) || (phase == EMPTY_PHASE);
        else fs = ($urandom_range(0, 63) == 0);
        send_word(WORD_W'($urandom_range(0, 65535)), fs, 1'b0, '0);
      end
    end

    // drain and report
    settle_idle();
    $display("Checked %0d results (%0d overruns) from %0d words over %0d register writes",
             results_seen, overruns_seen, words_sent, cfg_writes);
    $display("Covered %0d frame starts and %0d words dropped with no stripe enabled",
             frame_starts, dropped_words);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("%0t: timeout with %0d results outstanding", $time, loc_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ccd_psd_pkg.sv
rtl/core/ccd_psd_locate.sv
rtl/core/ccd_pixel_stripe_demux.sv
rtl/core/ccd_psd_checker.sv
tb/ccd_pixel_stripe_demux_test.sv
